@@ design/b32h_pkg.sv @@
// Shared types, constants and character mapping for the base32hex codec.
// No dependencies; used by b32h_core, b32h_out_buf and the top level of the codec.
`timescale 1ns / 1ps
`default_nettype none

package b32h_pkg;

  localparam int ACC_W       = 12;
  localparam int HELD_W      = 4;
  localparam int MAX_RESULTS = 3;
  localparam int ERR_POS_W   = 32;

  localparam logic DIRECTION_ENCODE = 1'b0;
  localparam logic DIRECTION_DECODE = 1'b1;

  // one result word
  typedef struct packed {
    logic [7:0]           value;
    logic                 is_error;
    logic [ERR_POS_W-1:0] err_pos;
    logic                 last;
  } result_t;

  typedef result_t [MAX_RESULTS-1:0] result_arr_t;

  // everything one input word produces
  typedef struct packed {
    logic [1:0]  count;
    result_arr_t res;
  } step_t;

  typedef struct packed {
    logic              direction;
    logic              failed;
    logic [HELD_W-1:0] bits_held;
  } status_t;

  function automatic logic [7:0] to_char(input logic [4:0] v);
    logic [7:0] r;
    if (v < 5'd10) r = 8'h30 + {3'b000, v};
    else           r = 8'h37 + {3'b000, v};
    return r;
  endfunction

  // {valid, 5-bit group}
  function automatic logic [5:0] from_char(input logic [7:0] c);
    logic [5:0] r;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 5'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h56) r = {1'b1, 5'(c - 8'h37)};
    else                               r = 6'd0;
    return r;
  endfunction

  function automatic logic [ACC_W-1:0] low_mask(input logic [HELD_W-1:0] n);
    return (ACC_W'(1) << n) - ACC_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ design/b32h_in_reg.sv @@
// Input register stage of the base32hex codec.
// Depends on nothing but the port handshake; feeds b32h_core.
`timescale 1ns / 1ps
`default_nettype none

module b32h_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_value,
  input  wire logic       in_is_last,
  input  wire logic       consume,
  output logic            valid_r,
  output logic [7:0]      value_r,
  output logic            last_r
);

  logic valid_nxt;

  assign in_ready = !valid_r || consume;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) valid_nxt = 1'b1;
    else if (consume)         valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      value_r <= in_value;
      last_r  <= in_is_last;
    end
  end

endmodule

`default_nettype wire

@@ design/b32h_core.sv @@
// Codec state and the single-pass encode/decode step for one word.
// Uses b32h_pkg; takes words from b32h_in_reg, hands results to b32h_out_buf.
`timescale 1ns / 1ps
`default_nettype none

module b32h_core #(
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_wr_data,
  input  wire logic         item_valid,
  input  wire logic [7:0]   item_value,
  input  wire logic         item_last,
  input  wire logic [1:0]   space,
  output logic              consume,
  output b32h_pkg::step_t   step,
  output b32h_pkg::status_t status
);

  localparam int POS_W = (POSITION_WIDTH < 32) ? POSITION_WIDTH : 32;
  localparam int AW    = b32h_pkg::ACC_W;
  localparam int HW    = b32h_pkg::HELD_W;

  logic             dir_r;
  logic [AW-1:0]    acc_r, acc_nxt;
  logic [HW-1:0]    held_r, held_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             failed_r, failed_nxt;

  // encode path
  logic [AW-1:0] enc_acc, enc_a1, enc_a2, enc_af;
  logic [HW-1:0] enc_held, enc_h1, enc_h2, enc_hf;
  logic [4:0]    enc_c0, enc_c1, enc_pad;
  logic          enc_two, enc_pad_en;

  // decode path
  logic [5:0]       dec_q;
  logic [AW-1:0]    dec_acc;
  logic [HW-1:0]    dec_h5;
  logic [POS_W-1:0] dec_pos_inc;

  b32h_pkg::step_t   step_c;
  b32h_pkg::result_t blank;

  always_comb begin
    enc_acc    = {acc_r[3:0], item_value};
    enc_held   = {1'b0, held_r[2:0]} + HW'(8);
    enc_c0     = 5'(enc_acc >> (enc_held - HW'(5)));
    enc_h1     = enc_held - HW'(5);
    enc_a1     = enc_acc & b32h_pkg::low_mask(enc_h1);
    enc_two    = enc_h1 >= HW'(5);
    enc_c1     = 5'(enc_a1 >> (enc_h1 - HW'(5)));
    enc_h2     = enc_h1 - HW'(5);
    enc_a2     = enc_a1 & b32h_pkg::low_mask(enc_h2);
    enc_hf     = enc_two ? enc_h2 : enc_h1;
    enc_af     = enc_two ? enc_a2 : enc_a1;
    enc_pad_en = item_last && (enc_hf != '0);
    // leftover bits go to the top of the final group
    enc_pad    = 5'(enc_af << (HW'(5) - enc_hf));
  end

  always_comb begin
    dec_q       = b32h_pkg::from_char(item_value);
    dec_acc     = {acc_r[6:0], dec_q[4:0]};
    dec_h5      = {1'b0, held_r[2:0]} + HW'(5);
    dec_pos_inc = (pos_r != '1) ? pos_r + POS_W'(1) : pos_r;
  end

  always_comb begin
    blank      = '0;
    step_c     = '0;
    acc_nxt    = acc_r;
    held_nxt   = held_r;
    pos_nxt    = pos_r;
    failed_nxt = failed_r;
    unique case (dir_r)
      b32h_pkg::DIRECTION_ENCODE: begin
        step_c.res[0]       = blank;
        step_c.res[0].value = b32h_pkg::to_char(enc_c0);
        step_c.res[1].value = b32h_pkg::to_char(enc_two ? enc_c1 : enc_pad);
        step_c.res[2].value = b32h_pkg::to_char(enc_pad);
        step_c.count        = 2'd1 + {1'b0, enc_two} + {1'b0, enc_pad_en};
        if (item_last) begin
          step_c.res[step_c.count - 2'd1].last = 1'b1;
          acc_nxt  = '0;
          held_nxt = '0;
          pos_nxt  = '0;
        end else begin
          acc_nxt  = enc_af;
          held_nxt = enc_hf;
        end
      end
      b32h_pkg::DIRECTION_DECODE: begin
        if (failed_r) begin
          if (item_last) begin
            acc_nxt    = '0;
            held_nxt   = '0;
            pos_nxt    = '0;
            failed_nxt = 1'b0;
          end
        end else if (!dec_q[5]) begin
          // bad character that completes no byte at end of message is dropped
          if (!(item_last && dec_h5 < HW'(8))) begin
            step_c.count           = 2'd1;
            step_c.res[0].is_error = 1'b1;
            step_c.res[0].err_pos  = b32h_pkg::ERR_POS_W'(pos_r);
            step_c.res[0].last     = item_last;
          end
          if (item_last) begin
            acc_nxt    = '0;
            held_nxt   = '0;
            pos_nxt    = '0;
          end else begin
            failed_nxt = 1'b1;
            pos_nxt    = dec_pos_inc;
          end
        end else begin
          if (dec_h5 >= HW'(8)) begin
            step_c.count        = 2'd1;
            step_c.res[0].value = 8'(dec_acc >> (dec_h5 - HW'(8)));
            step_c.res[0].last  = item_last;
          end
          if (item_last) begin
            acc_nxt  = '0;
            held_nxt = '0;
            pos_nxt  = '0;
          end else if (dec_h5 >= HW'(8)) begin
            held_nxt = dec_h5 - HW'(8);
            acc_nxt  = dec_acc & b32h_pkg::low_mask(dec_h5 - HW'(8));
            pos_nxt  = dec_pos_inc;
          end else begin
            held_nxt = dec_h5;
            acc_nxt  = dec_acc;
            pos_nxt  = dec_pos_inc;
          end
        end
      end
      default: ;
    endcase
  end

  assign step    = step_c;
  assign consume = item_valid && (step_c.count <= space);

  assign status.direction = dir_r;
  assign status.failed    = failed_r;
  assign status.bits_held = held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= b32h_pkg::DIRECTION_ENCODE;
      acc_r    <= '0;
      held_r   <= '0;
      pos_r    <= '0;
      failed_r <= 1'b0;
    end else if (cfg_wr_en) begin
      // a direction write aborts any message in flight
      dir_r    <= cfg_wr_data;
      acc_r    <= '0;
      held_r   <= '0;
      pos_r    <= '0;
      failed_r <= 1'b0;
    end else if (consume) begin
      acc_r    <= acc_nxt;
      held_r   <= held_nxt;
      pos_r    <= pos_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/b32h_out_buf.sv @@
// Three-word result buffer of the base32hex codec; head word drives the port.
// Uses b32h_pkg; filled by b32h_core.
`timescale 1ns / 1ps
`default_nettype none

module b32h_out_buf (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire b32h_pkg::step_t step,
  output logic [1:0]           space,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_value,
  output logic                 out_is_error,
  output logic [31:0]          out_error_position,
  output logic                 out_last_of_message
);

  localparam int N = b32h_pkg::MAX_RESULTS;

  b32h_pkg::result_t [N-1:0] slots_r, slots_nxt, shifted;
  logic [1:0] count_r, count_nxt, cnt_after;
  logic [2:0] k;
  logic       pop;

  assign out_valid = count_r != 2'd0;
  assign pop       = out_valid && out_ready;
  // space is taken before this cycle's pop, so ready never waits on out_ready
  assign space     = 2'd3 - count_r;
  assign cnt_after = count_r - {1'b0, pop};

  always_comb begin
    shifted = slots_r;
    if (pop) begin
      for (int i = 0; i < N - 1; i++) shifted[i] = slots_r[i+1];
    end
    slots_nxt = shifted;
    k         = '0;
    for (int i = 0; i < N; i++) begin
      k = 3'(i) - {1'b0, cnt_after};
      if (push && 3'(i) >= {1'b0, cnt_after} && k < {1'b0, step.count}) begin
        slots_nxt[i] = step.res[k[1:0]];
      end
    end
    count_nxt = cnt_after + (push ? step.count : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slots_r <= slots_nxt;
  end

  assign out_value           = slots_r[0].value;
  assign out_is_error        = slots_r[0].is_error;
  assign out_error_position  = slots_r[0].err_pos;
  assign out_last_of_message = slots_r[0].last;

endmodule

`default_nettype wire

@@ design/base32hex_stream_codec_unit.sv @@
// Top level of the streaming base32hex (0-9, A-V, unpadded) codec.
// Instantiates b32h_in_reg, b32h_core and b32h_out_buf; uses b32h_pkg.
//
// Streams bytes to base32hex characters (cfg direction 0) or characters back
// to bytes (direction 1); in_is_last ends a message. A word passes an input
// register and its results wait in a three-word buffer. Decode takes one word
// per cycle while the buffer has room. Encode gives one or two characters per
// byte (three on a last byte with leftover bits) and the port moves one result
// per cycle while out_ready is high, so bytes go in more slowly than characters
// leave. A bad character while decoding gives one error word (value 0, position
// within the message, saturating) and the rest of that message is dropped up to
// its last word. Direction is to be written only while idle; the block does not
// enforce it. Each write clears the message state.
`timescale 1ns / 1ps
`default_nettype none

module base32hex_stream_codec_unit #(
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_value,
  input  wire logic        in_is_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_value,
  output logic             out_is_error,
  output logic [31:0]      out_error_position,
  output logic             out_last_of_message
);

  logic              item_valid, item_last, consume;
  logic [7:0]        item_value;
  logic [1:0]        space;
  b32h_pkg::step_t   step;
  b32h_pkg::status_t status;

  b32h_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_value  (in_value),
    .in_is_last(in_is_last),
    .consume   (consume),
    .valid_r   (item_valid),
    .value_r   (item_value),
    .last_r    (item_last)
  );

  b32h_core #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .item_valid (item_valid),
    .item_value (item_value),
    .item_last  (item_last),
    .space      (space),
    .consume    (consume),
    .step       (step),
    .status     (status)
  );

  b32h_out_buf u_out_buf (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (consume),
    .step               (step),
    .space              (space),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_value          (out_value),
    .out_is_error       (out_is_error),
    .out_error_position (out_error_position),
    .out_last_of_message(out_last_of_message)
  );

  // encoder never holds a full group between bytes
  a_enc_held: assert property (@(posedge clk) disable iff (!rst_n)
    status.direction == b32h_pkg::DIRECTION_ENCODE |-> status.bits_held < 4'd5)
    else $error("encode leftover bit count out of range");

  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_error |-> out_value == 8'd0)
    else $error("error word carries a nonzero value");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_error |-> out_error_position == 32'd0)
    else $error("data word carries an error position");

  a_fail_dir: assert property (@(posedge clk) disable iff (!rst_n)
    status.failed |-> status.direction == b32h_pkg::DIRECTION_DECODE)
    else $error("failed flag set while encoding");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for base32hex_stream_codec_unit: encode and decode messages,
// bad characters, direction changes, random idles and a long output stall.
// Depends on b32h_pkg (result_t, direction codes) and the codec RTL.
`timescale 1ns / 1ps

module tb;

  // Tracks codec state and holds the words the block still owes us.
  class codec_scoreboard;
    logic                 direction;
    logic [11:0]          acc;
    logic [3:0]           held;
    logic [31:0]          char_pos;
    logic                 failed;
    b32h_pkg::result_t    expected_words[$];
    int                   errors;

    function new();
      direction = b32h_pkg::DIRECTION_ENCODE;
      errors = 0;
      clear_message();
    endfunction

    function void clear_message();
      acc = '0;
      held = '0;
      char_pos = '0;
      failed = 1'b0;
    endfunction

    function void set_direction(logic d);
      direction = d;
      clear_message();
    endfunction

    function logic [7:0] hex32_char(logic [4:0] g);
      logic [7:0] c;
      if (g < 5'd10) c = 8'h30 + 8'(g);
      else           c = 8'h41 + 8'(g - 5'd10);
      return c;
    endfunction

    // -1 for anything outside 0-9, A-V
    function int hex32_group(logic [7:0] c);
      int g;
      if (c >= 8'h30 && c <= 8'h39)      g = int'(c) - 'h30;
      else if (c >= 8'h41 && c <= 8'h56) g = int'(c) - 'h41 + 10;
      else                               g = -1;
      return g;
    endfunction

    function void queue_word(logic [7:0] v, logic e, logic [31:0] p, logic l);
      b32h_pkg::result_t r;
      r.value = v;
      r.is_error = e;
      r.err_pos = p;
      r.last = l;
      expected_words.push_back(r);
    endfunction

    // Predict the words caused by one accepted input word.
    function void take_input(logic [7:0] v, logic l);
      logic [11:0] a;
      logic [7:0]  chars[3];
      logic [31:0] pos;
      int          h;
      int          n;
      int          g;
      int          i;
      if (direction == b32h_pkg::DIRECTION_ENCODE) begin
        a = {acc[3:0], v};
        h = int'(held[2:0]) + 8;
        n = 0;
        while (h >= 5) begin
          h -= 5;
          chars[n] = hex32_char(5'(a >> h));
          n++;
          a = a & ((12'd1 << h) - 12'd1);
        end
        // leftover bits are zero-padded on the right
        if (l && h > 0) begin
          chars[n] = hex32_char(5'(a << (5 - h)));
          n++;
        end
        for (i = 0; i < n; i++) queue_word(chars[i], 1'b0, '0, l && (i == n - 1));
        if (l) clear_message();
        else begin
          acc = a;
          held = 4'(h);
        end
      end else if (failed) begin
        if (l) clear_message();
      end else begin
        g = hex32_group(v);
        h = int'(held[2:0]);
        pos = char_pos;
        if (char_pos != 32'hFFFF_FFFF) char_pos++;
        if (g < 0) begin
          // a bad final char that completes no byte goes unflagged
          if (l && h + 5 < 8) clear_message();
          else begin
            queue_word(8'h00, 1'b1, pos, l);
            if (l) clear_message();
            else failed = 1'b1;
          end
        end else begin
          a = {acc[6:0], 5'(g)};
          h += 5;
          if (h >= 8) begin
            h -= 8;
            queue_word(8'(a >> h), 1'b0, '0, l);
            a = a & ((12'd1 << h) - 12'd1);
          end
          if (l) clear_message();
          else begin
            acc = a;
            held = 4'(h);
          end
        end
      end
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_output(logic [7:0] v, logic e, logic [31:0] p, logic l);
      b32h_pkg::result_t x;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word value=%02h err=%0b pos=%0d last=%0b", v, e, p, l));
        return;
      end
      x = expected_words.pop_front();
      if (v !== x.value)
        report($sformatf("value %02h, expected %02h", v, x.value));
      if (e !== x.is_error)
        report($sformatf("is_error %0b, expected %0b", e, x.is_error));
      if (p !== x.err_pos)
        report($sformatf("error_position %0d, expected %0d", p, x.err_pos));
      if (l !== x.last)
        report($sformatf("last_of_message %0b, expected %0b", l, x.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_value;
  logic        in_is_last;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_value;
  logic        out_is_error;
  logic [31:0] out_error_position;
  logic        out_last_of_message;

  codec_scoreboard sb;
  bit              stall_req = 1'b0;
  bit              stall_taken = 1'b0;

  base32hex_stream_codec_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_value            (in_value),
    .in_is_last          (in_is_last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_value           (out_value),
    .out_is_error        (out_is_error),
    .out_error_position  (out_error_position),
    .out_last_of_message (out_last_of_message)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly back-to-back, some short gaps, a few long ones
  function int pick_gap();
    int r;
    r = $urandom % 100;
    if (r < 55)      return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else             return $urandom_range(8, 24);
  endfunction

  function logic [7:0] pick_char();
    logic [7:0] c;
    int r;
    r = $urandom % 100;
    if (r < 82) c = sb.hex32_char(5'($urandom_range(0, 31)));
    else if (r < 94) begin
      do c = 8'($urandom_range(0, 255)); while (sb.hex32_group(c) >= 0);
    end else c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task send_word(input logic [7:0] v, input logic l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= v;
    in_is_last <= l;
    do @(posedge clk); while (!in_ready);
    sb.take_input(v, l);
  endtask

  task send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  task drop_valid();
    @(negedge clk) in_valid <= 1'b0;
  endtask

  // words without results may still be in the pipe after the last result
  task wait_idle();
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task write_direction(input logic d);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= d;
    @(negedge clk) cfg_wr_en <= 1'b0;
    sb.set_direction(d);
  endtask

  // receiver: random ready pattern plus one long hold-off on request
  initial begin
    int run;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (stall_req && !stall_taken) begin
        out_ready <= 1'b0;
        run = 80;
        stall_taken = 1'b1;
      end else if ($urandom % 3 == 0) begin
        out_ready <= 1'b0;
        run = ($urandom % 10 == 0) ? $urandom_range(10, 25) : $urandom_range(1, 3);
      end else begin
        out_ready <= 1'b1;
        run = ($urandom % 8 == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      end
      // a pending hold-off request cuts the current run short
      repeat (run) begin
        @(negedge clk);
        if (stall_req && !stall_taken) break;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_output(out_value, out_is_error, out_error_position, out_last_of_message);
  end

  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic dir;
    int   ph;
    int   sent;
    int   len;
    int   i;
    sb = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    in_is_last = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // encode from reset: single byte, a full 5-byte cycle, a 3-char last byte
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'hA5, 1'b0);
    send_word(8'h5A, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(8'h3C, 1'b0);
    send_word(8'hC3, 1'b1);
    // leave a message open; the direction write must abort it
    send_word(8'h12, 1'b0);
    drop_valid();
    wait_idle();
    write_direction(b32h_pkg::DIRECTION_DECODE);

    send_text("09AV");
    send_text("VVV");                 // last char completes no byte
    send_word("1", 1'b0);
    send_word(":", 1'b0);             // bad char mid-message, rest dropped
    send_word("a", 1'b0);
    send_word(8'h00, 1'b1);
    send_text("AW");                  // bad last char that completes a byte
    send_word("@", 1'b1);             // bad last char, no byte: unflagged
    send_word("a", 1'b0);             // lowercase at position 0
    send_word(8'hFF, 1'b1);
    drop_valid();
    wait_idle();

    for (ph = 0; ph < 8; ph++) begin
      dir = (ph % 3 == 1) ? b32h_pkg::DIRECTION_ENCODE : b32h_pkg::DIRECTION_DECODE;
      write_direction(dir);
      if (ph == 1) stall_req = 1'b1;
      sent = 0;
      while (sent < 22) begin
        if (dir == b32h_pkg::DIRECTION_ENCODE) begin
          len = $urandom_range(1, 8);
          for (i = 0; i < len; i++) send_word(8'($urandom_range(0, 255)), i == len - 1);
        end else begin
          len = $urandom_range(1, 10);
          for (i = 0; i < len; i++) send_word(pick_char(), i == len - 1);
        end
        sent += len;
      end
      drop_valid();
      wait_idle();
    end

    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
